[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a condition at every clock edge outside reset
`define GSA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// check a condition in the cycle after a trigger
`define GSA_ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) trig |=> prop) else $error(msg);

`endif

[design/gsa_pkg.sv]
package gsa_pkg;

    localparam int SLOTS    = 1024;
    localparam int GEN_BITS = 12;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    localparam int MODE_W   = 2;
    localparam int IN_IDX_W = 10;
    localparam int IN_GEN_W = 12;
    localparam int STATUS_W = 2;
    localparam int LIVE_W   = 11;
    localparam int CMP_W    = (GEN_BITS > IN_GEN_W) ? GEN_BITS : IN_GEN_W;

    localparam logic [MODE_W-1:0] MODE_CREATE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DESTROY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic load;
        logic rd_tables;
        logic rd_slot;
        logic commit;
    } gsa_cmd_t;

    typedef struct packed {
        logic out_free;
    } gsa_stat_t;

endpackage

[design/generational_slot_allocator_core.sv]
// Generational slot allocator: create, destroy and query handles made of a slot index and a
// per-slot generation. Each item passes in order through the accept cycle, a read of the free stack
// and packed-list tables, a read of the slot table at the address just found, and commit. The
// result is registered at commit. The slot-table read depends on the free-stack read, and no
// new item is accepted until the current one commits. A result waiting in the output register
// holds the commit until taken; the next item can be accepted the cycle after the commit.
// No clearing pass follows reset: slots at or above the high-water mark read as dead with
// generation zero, so the block accepts items right after reset.
module generational_slot_allocator_core
    import gsa_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [MODE_W-1:0]   s_mode,
    input  logic [IN_IDX_W-1:0] s_slot_index,
    input  logic [IN_GEN_W-1:0] s_slot_generation,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [IN_IDX_W-1:0] m_handle_index,
    output logic [IN_GEN_W-1:0] m_handle_generation,
    output logic                m_is_live,
    output logic [LIVE_W-1:0]   m_live_count
);

    gsa_cmd_t  cmd;
    gsa_stat_t stat;

    gsa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    gsa_datapath u_datapath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .stat                (stat),
        .s_mode              (s_mode),
        .s_slot_index        (s_slot_index),
        .s_slot_generation   (s_slot_generation),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_handle_index      (m_handle_index),
        .m_handle_generation (m_handle_generation),
        .m_is_live           (m_is_live),
        .m_live_count        (m_live_count)
    );

endmodule

[design/gsa_ctrl.sv]
module gsa_ctrl
    import gsa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  gsa_stat_t stat,
    output gsa_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ_TABLES,
        ST_READ_SLOT,
        ST_EXEC
    } state_t;

    state_t state_reg;
    logic   ready_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && ready_reg) begin
                        state_reg <= ST_READ_TABLES;
                        ready_reg <= 1'b0;
                    end else begin
                        ready_reg <= 1'b1;
                    end
                end
                ST_READ_TABLES: begin
                    state_reg <= ST_READ_SLOT;
                end
                ST_READ_SLOT: begin
                    state_reg <= ST_EXEC;
                end
                ST_EXEC: begin
                    if (stat.out_free) begin
                        state_reg <= ST_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                    ready_reg <= 1'b0;
                end
            endcase
        end
    end

    assign s_ready = ready_reg;

    always_comb begin
        cmd.load      = (state_reg == ST_IDLE) && s_valid && ready_reg;
        cmd.rd_tables = (state_reg == ST_READ_TABLES);
        cmd.rd_slot   = (state_reg == ST_READ_SLOT);
        cmd.commit    = (state_reg == ST_EXEC) && stat.out_free;
    end

endmodule

[design/gsa_datapath.sv]
module gsa_datapath
    import gsa_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  gsa_cmd_t            cmd,
    output gsa_stat_t           stat,
    input  logic [MODE_W-1:0]   s_mode,
    input  logic [IN_IDX_W-1:0] s_slot_index,
    input  logic [IN_GEN_W-1:0] s_slot_generation,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [IN_IDX_W-1:0] m_handle_index,
    output logic [IN_GEN_W-1:0] m_handle_generation,
    output logic                m_is_live,
    output logic [LIVE_W-1:0]   m_live_count
);

    logic [GEN_BITS:0] slot_mem [SLOTS];
    logic [IDX_W-1:0]  pos_mem  [SLOTS];
    logic [IDX_W-1:0]  list_mem [SLOTS];
    logic [IDX_W-1:0]  free_mem [SLOTS];

    logic [MODE_W-1:0]   mode_reg;
    logic [IN_IDX_W-1:0] idx_reg;
    logic [IN_GEN_W-1:0] gen_reg;

    logic [IDX_W-1:0]  free_rd_reg;
    logic [IDX_W-1:0]  pos_rd_reg;
    logic [IDX_W-1:0]  list_rd_reg;
    logic [GEN_BITS:0] slot_rd_reg;
    logic [IDX_W-1:0]  slot_addr_reg;
    logic              in_range_reg;

    logic [CNT_W-1:0] free_depth_reg, free_depth_next;
    logic [CNT_W-1:0] high_mark_reg, high_mark_next;
    logic [CNT_W-1:0] live_total_reg, live_total_next;

    logic                m_valid_reg;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [IN_IDX_W-1:0] h_idx_reg, h_idx_next;
    logic [IN_GEN_W-1:0] h_gen_reg, h_gen_next;
    logic                live_reg, live_next;
    logic [LIVE_W-1:0]   count_reg;

    logic             is_create, is_destroy, is_query;
    logic             have_free;
    logic [CNT_W-1:0] slot_src;
    logic             cur_live;
    logic [GEN_BITS-1:0] cur_gen;
    logic             handle_ok;
    logic             got, create_ok, destroy_ok;

    logic              slot_we;
    logic [GEN_BITS:0] slot_wdata;
    logic              pos_we;
    logic [IDX_W-1:0]  pos_waddr, pos_wdata;
    logic              list_we;
    logic [IDX_W-1:0]  list_waddr, list_wdata;
    logic              free_we;

    always_comb begin
        is_create  = (mode_reg == MODE_CREATE);
        is_destroy = (mode_reg == MODE_DESTROY);
        is_query   = (mode_reg == MODE_QUERY);
        have_free  = (free_depth_reg != '0);

        if (is_create) begin
            slot_src = have_free ? CNT_W'(free_rd_reg) : high_mark_reg;
        end else begin
            slot_src = CNT_W'(idx_reg);
        end

        cur_live  = in_range_reg & slot_rd_reg[GEN_BITS];
        cur_gen   = in_range_reg ? slot_rd_reg[GEN_BITS-1:0] : '0;
        handle_ok = cur_live && (CMP_W'(cur_gen) == CMP_W'(gen_reg));

        got        = have_free || (high_mark_reg < CNT_W'(SLOTS));
        create_ok  = is_create && got && (live_total_reg < CNT_W'(SLOTS));
        destroy_ok = is_destroy && handle_ok && (live_total_reg != '0);

        free_depth_next = free_depth_reg;
        high_mark_next  = high_mark_reg;
        live_total_next = live_total_reg;
        if (is_create && got) begin
            if (have_free) begin
                free_depth_next = free_depth_reg - CNT_W'(1);
            end else begin
                high_mark_next = high_mark_reg + CNT_W'(1);
            end
        end
        if (create_ok) begin
            live_total_next = live_total_reg + CNT_W'(1);
        end
        if (destroy_ok) begin
            live_total_next = live_total_reg - CNT_W'(1);
            if (free_depth_reg < CNT_W'(SLOTS)) begin
                free_depth_next = free_depth_reg + CNT_W'(1);
            end
        end

        slot_we    = create_ok || destroy_ok;
        slot_wdata = create_ok ? {1'b1, cur_gen} : {1'b0, cur_gen + GEN_BITS'(1)};

        pos_we     = create_ok || destroy_ok;
        pos_waddr  = create_ok ? slot_addr_reg : list_rd_reg;
        pos_wdata  = create_ok ? IDX_W'(live_total_reg) : pos_rd_reg;
        list_we    = create_ok || destroy_ok;
        list_waddr = create_ok ? IDX_W'(live_total_reg) : pos_rd_reg;
        list_wdata = create_ok ? slot_addr_reg : list_rd_reg;
        free_we    = destroy_ok && (free_depth_reg < CNT_W'(SLOTS));

        status_next = ST_OK;
        h_idx_next  = '0;
        h_gen_next  = '0;
        live_next   = 1'b0;
        if (is_create) begin
            if (create_ok) begin
                h_idx_next = IN_IDX_W'(slot_addr_reg);
                h_gen_next = IN_GEN_W'(cur_gen);
            end else begin
                status_next = ST_FULL;
            end
        end else if (is_destroy) begin
            if (!destroy_ok) begin
                status_next = ST_INVALID;
            end
        end else if (is_query) begin
            live_next = handle_ok;
        end else begin
            status_next = ST_INVALID;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_tables) begin
            free_rd_reg <= free_mem[IDX_W'(free_depth_reg - CNT_W'(1))];
            pos_rd_reg  <= pos_mem[IDX_W'(idx_reg)];
            list_rd_reg <= list_mem[IDX_W'(live_total_reg - CNT_W'(1))];
        end
        if (cmd.rd_slot) begin
            slot_rd_reg <= slot_mem[IDX_W'(slot_src)];
        end
        if (cmd.commit) begin
            if (slot_we) begin
                slot_mem[slot_addr_reg] <= slot_wdata;
            end
            if (pos_we) begin
                pos_mem[pos_waddr] <= pos_wdata;
            end
            if (list_we) begin
                list_mem[list_waddr] <= list_wdata;
            end
            if (free_we) begin
                free_mem[IDX_W'(free_depth_reg)] <= IDX_W'(idx_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg <= s_mode;
            idx_reg  <= s_slot_index;
            gen_reg  <= s_slot_generation;
        end
        if (cmd.rd_slot) begin
            slot_addr_reg <= IDX_W'(slot_src);
            in_range_reg  <= (slot_src < high_mark_reg);
        end
        if (cmd.commit) begin
            status_reg <= status_next;
            h_idx_reg  <= h_idx_next;
            h_gen_reg  <= h_gen_next;
            live_reg   <= live_next;
            count_reg  <= LIVE_W'(live_total_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_depth_reg <= '0;
            high_mark_reg  <= '0;
            live_total_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.commit) begin
                free_depth_reg <= free_depth_next;
                high_mark_reg  <= high_mark_next;
                live_total_reg <= live_total_next;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.out_free       = !m_valid_reg || m_ready;
    assign m_valid             = m_valid_reg;
    assign m_status            = status_reg;
    assign m_handle_index      = h_idx_reg;
    assign m_handle_generation = h_gen_reg;
    assign m_is_live           = live_reg;
    assign m_live_count        = count_reg;

endmodule

[design/gsa_checker.sv]
`include "assert_macros.svh"

module gsa_checker
    import gsa_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic [STATUS_W-1:0] m_status,
    input logic [IN_IDX_W-1:0] m_handle_index,
    input logic [IN_GEN_W-1:0] m_handle_generation,
    input logic                m_is_live,
    input logic [LIVE_W-1:0]   m_live_count
);

    `GSA_ASSERT_NEXT(a_one_item_at_a_time, s_valid && s_ready, !s_ready, "ready held after accept")
    `GSA_ASSERT_ALWAYS(a_status_code, !m_valid || m_status == ST_OK || m_status == ST_INVALID || m_status == ST_FULL, "bad status code")
    `GSA_ASSERT_ALWAYS(a_failed_no_handle, !(m_valid && m_status != ST_OK) || (m_handle_index == '0 && m_handle_generation == '0 && !m_is_live), "failed item carries handle")
    `GSA_ASSERT_ALWAYS(a_full_at_capacity, !(m_valid && m_status == ST_FULL) || m_live_count == LIVE_W'(SLOTS), "full reported below capacity")
    `GSA_ASSERT_ALWAYS(a_live_bound, !m_valid || m_live_count <= LIVE_W'(SLOTS), "live count above capacity")

endmodule

bind generational_slot_allocator_core gsa_checker u_gsa_checker (.*);
